### hdl/lattice_scalar_action_engine_macros.svh
// Assertion macros shared by the lattice action engine RTL.
`ifndef LATTICE_SCALAR_ACTION_ENGINE_MACROS_SVH
`define LATTICE_SCALAR_ACTION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSAE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSAE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lsae_pkg.sv
// Shared constants, widths and helpers for the lattice action engine.
`timescale 1ns / 1ps
package lsae_pkg;

  localparam int unsigned DEF_EXTENT_T = 8;
  localparam int unsigned DEF_EXTENT_X = 8;
  localparam int unsigned DEF_EXTENT_Y = 8;
  localparam int unsigned DEF_EXTENT_Z = 8;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned WORD_W   = 2 * VAL_W;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned SUM_W    = 19;
  localparam int unsigned TERM_W   = 34;
  localparam int unsigned ACT_W    = 48;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_DELTA = 2'd1;
  localparam logic [1:0] MODE_TOTAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_QUARTIC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOPPING = CFG_IDX_W'(1);

  localparam logic KIND_DELTA = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // Reduces a three-bit coordinate modulo an extent of at least two.
  function automatic logic [2:0] coord_mod(input logic [2:0] c, input int unsigned e);
    logic [6:0] v;
    v = {4'd0, c};
    for (int i = 0; i < 3; i++) begin
      if (v >= 7'(e)) begin
        v = v - 7'(e);
      end
    end
    return v[2:0];
  endfunction

endpackage

### hdl/lsae_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module lsae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/lsae_term.sv
// Six-stage pipeline computing a local term minus a hopping term.
`timescale 1ns / 1ps
module lsae_term import lsae_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [15:0]              lambda,
  input  logic [15:0]              kappa,
  input  logic                     in_valid,
  input  logic signed [VAL_W-1:0]  in_v_re,
  input  logic signed [VAL_W-1:0]  in_v_im,
  input  logic signed [DIFF_W-1:0] in_a_re,
  input  logic signed [DIFF_W-1:0] in_a_im,
  input  logic signed [SUM_W-1:0]  in_b_re,
  input  logic signed [SUM_W-1:0]  in_b_im,
  output logic                     out_valid,
  output logic signed [TERM_W-1:0] out_term,
  output logic                     busy
);

  logic [5:0] v_r;

  logic signed [31:0] sq_re, sq_im;
  logic signed [35:0] pa, pb;
  logic [31:0]        s1_m_r;
  logic signed [35:0] s1_pa_r, s1_pb_r;

  logic signed [32:0] d;
  logic [30:0]        s2_absd_r;
  logic [23:0]        s2_m8_r;
  logic signed [36:0] s2_h_r;

  logic [61:0]        s3_q_r;
  logic [23:0]        s3_m8_r;
  logic signed [37:0] s3_khl_r;
  logic signed [33:0] s3_khh_r;

  logic [46:0]        s4_lql_r, s4_lqh_r;
  logic [23:0]        s4_m8_r;
  logic signed [53:0] s4_kh_r;

  logic [77:0]        lq;
  logic [29:0]        s5_part_r;
  logic [23:0]        s5_m8_r;
  logic signed [30:0] s5_hop_r;

  logic signed [TERM_W-1:0] s6_term_r;

  assign sq_re = in_v_re * in_v_re;
  assign sq_im = in_v_im * in_v_im;
  assign pa    = in_a_re * in_b_re;
  assign pb    = in_a_im * in_b_im;
  assign d     = $signed({1'b0, s1_m_r}) - $signed(33'(1 << 24));
  assign lq    = {s4_lqh_r, 31'd0} + {31'd0, s4_lql_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
    // Stage 1: squares and hopping products.
    s1_m_r  <= $unsigned(sq_re) + $unsigned(sq_im);
    s1_pa_r <= pa;
    s1_pb_r <= pb;
    // Stage 2: distance from unit modulus, hopping sum.
    s2_absd_r <= d[32] ? 31'(-d) : d[30:0];
    s2_m8_r   <= s1_m_r[31:8];
    s2_h_r    <= {s1_pa_r[35], s1_pa_r} + {s1_pb_r[35], s1_pb_r};
    // Stage 3: square of the distance; kappa times the split hopping sum.
    s3_q_r   <= s2_absd_r * s2_absd_r;
    s3_m8_r  <= s2_m8_r;
    s3_khl_r <= $signed({1'b0, kappa}) * $signed({1'b0, s2_h_r[19:0]});
    s3_khh_r <= $signed({1'b0, kappa}) * $signed(s2_h_r[36:20]);
    // Stage 4: lambda times the split square; recombine the hopping product.
    s4_lql_r <= lambda * s3_q_r[30:0];
    s4_lqh_r <= lambda * s3_q_r[61:31];
    s4_m8_r  <= s3_m8_r;
    s4_kh_r  <= $signed({s3_khh_r, 20'd0}) + {{16{s3_khl_r[37]}}, s3_khl_r};
    // Stage 5: floors of both products.
    s5_part_r <= lq[77:48];
    s5_m8_r   <= s4_m8_r;
    s5_hop_r  <= s4_kh_r[53:23];
    // Stage 6: combine.
    s6_term_r <= $signed({4'd0, s5_part_r}) + $signed({10'd0, s5_m8_r})
               - {{(TERM_W-31){s5_hop_r[30]}}, s5_hop_r};
  end

  assign out_valid = v_r[5];
  assign out_term  = s6_term_r;
  assign busy      = |v_r;

endmodule

### hdl/lattice_scalar_action_engine.sv
// Top level of the lattice action engine: sequencer, lattice memory and result logic.
//
// Usage. A command is taken when start is high and busy is low; in_mode selects it.
// A site write (mode 0) goes to the lattice memory at that edge and leaves busy low.
// A delta query (mode 1) reads the eight neighbours and the site itself, one word a
// cycle through the single memory port, then passes two operands through the
// six-stage arithmetic pipe; its result is shown in the cycle in which busy has
// fallen, so a new command can be taken while it is shown.
// A total query (mode 2) walks every site in lattice order, five reads per site, and
// passes each site through the capture state into the pipe. Mode 3 is taken and
// ignored. Each result is shown for one cycle with out_valid; the receiver takes it
// then and cannot stall the block. Registers are written on the cfg channel, which is
// always ready; the user must write them only while the block is idle, which the block
// itself does not enforce. Reset returns the sequencer to idle and clears the
// couplings; lattice contents stay undefined until written. Memory reads happen only
// while busy and writes only while idle, so the two never collide.
`timescale 1ns / 1ps
`include "lattice_scalar_action_engine_macros.svh"
module lattice_scalar_action_engine import lsae_pkg::*; #(
  parameter int unsigned EXTENT_T = DEF_EXTENT_T,
  parameter int unsigned EXTENT_X = DEF_EXTENT_X,
  parameter int unsigned EXTENT_Y = DEF_EXTENT_Y,
  parameter int unsigned EXTENT_Z = DEF_EXTENT_Z
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [2:0]            in_coord_t,
  input  logic [2:0]            in_coord_x,
  input  logic [2:0]            in_coord_y,
  input  logic [2:0]            in_coord_z,
  input  logic signed [15:0]    in_value_re,
  input  logic signed [15:0]    in_value_im,
  output logic                  out_valid,
  output logic signed [47:0]    out_action_value,
  output logic                  out_result_kind,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int unsigned TW    = $clog2(EXTENT_T);
  localparam int unsigned XW    = $clog2(EXTENT_X);
  localparam int unsigned YW    = $clog2(EXTENT_Y);
  localparam int unsigned ZW    = $clog2(EXTENT_Z);
  localparam int unsigned AW    = TW + XW + YW + ZW;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [3:0] DIR_CENTER = 4'd0;
  localparam logic [3:0] DIR_TP     = 4'd1;
  localparam logic [3:0] DIR_XP     = 4'd2;
  localparam logic [3:0] DIR_YP     = 4'd3;
  localparam logic [3:0] DIR_ZP     = 4'd4;
  localparam logic [3:0] DIR_TM     = 4'd5;
  localparam logic [3:0] DIR_XM     = 4'd6;
  localparam logic [3:0] DIR_YM     = 4'd7;
  localparam logic [3:0] DIR_ZM     = 4'd8;
  localparam logic [3:0] LAST_DELTA_RD = 4'd8;
  localparam logic [3:0] LAST_TOTAL_RD = 4'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DRD, ST_DCAP, ST_DOP1, ST_DOP2, ST_DWAIT, ST_TRD, ST_TWAIT
  } state_t;

  // Total mode reuses the capture state, through flags, also as its issue state.
  state_t state_r;
  logic   tot_r, tcap_r, first_r;
  logic [3:0] cnt_r, rtag_r, dir;
  logic   rvalid_r;

  logic [TW-1:0] t_r, tp, tm;
  logic [XW-1:0] x_r, xp, xm;
  logic [YW-1:0] y_r, yp, ym;
  logic [ZW-1:0] z_r, zp, zm;

  logic [15:0] lambda_r, kappa_r;
  logic signed [VAL_W-1:0] p_re_r, p_im_r, ctr_re_r, ctr_im_r;
  logic signed [SUM_W-1:0] sum_re_r, sum_im_r;
  logic signed [TERM_W-1:0] t1_r;
  logic signed [ACT_W-1:0]  acc_r;

  logic          mem_we;
  logic [AW-1:0] mem_addr, wr_addr;
  logic [WORD_W-1:0] mem_rdata;
  logic signed [VAL_W-1:0] rd_re, rd_im;

  logic                     u_valid, term_valid, term_busy;
  logic signed [VAL_W-1:0]  u_v_re, u_v_im;
  logic signed [DIFF_W-1:0] u_a_re, u_a_im;
  logic signed [SUM_W-1:0]  u_b_re, u_b_im;
  logic signed [TERM_W-1:0] term;

  logic signed [ACT_W:0]    acc_sum;
  logic signed [TERM_W:0]   delta;
  logic                     accept, last_site;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign wr_addr = {TW'(coord_mod(in_coord_t, EXTENT_T)), XW'(coord_mod(in_coord_x, EXTENT_X)),
                    YW'(coord_mod(in_coord_y, EXTENT_Y)), ZW'(coord_mod(in_coord_z, EXTENT_Z))};

  assign tp = (t_r == TW'(EXTENT_T - 1)) ? '0 : t_r + TW'(1);
  assign xp = (x_r == XW'(EXTENT_X - 1)) ? '0 : x_r + XW'(1);
  assign yp = (y_r == YW'(EXTENT_Y - 1)) ? '0 : y_r + YW'(1);
  assign zp = (z_r == ZW'(EXTENT_Z - 1)) ? '0 : z_r + ZW'(1);
  assign tm = (t_r == '0) ? TW'(EXTENT_T - 1) : t_r - TW'(1);
  assign xm = (x_r == '0) ? XW'(EXTENT_X - 1) : x_r - XW'(1);
  assign ym = (y_r == '0) ? YW'(EXTENT_Y - 1) : y_r - YW'(1);
  assign zm = (z_r == '0) ? ZW'(EXTENT_Z - 1) : z_r - ZW'(1);

  // Delta reads visit the eight neighbours first and the site last.
  assign dir = (state_r == ST_DRD) ? ((cnt_r == LAST_DELTA_RD) ? DIR_CENTER : cnt_r + 4'd1)
                                   : cnt_r;

  always_comb begin
    unique case (dir)
      DIR_TP:  mem_addr = {tp, x_r, y_r, z_r};
      DIR_XP:  mem_addr = {t_r, xp, y_r, z_r};
      DIR_YP:  mem_addr = {t_r, x_r, yp, z_r};
      DIR_ZP:  mem_addr = {t_r, x_r, y_r, zp};
      DIR_TM:  mem_addr = {tm, x_r, y_r, z_r};
      DIR_XM:  mem_addr = {t_r, xm, y_r, z_r};
      DIR_YM:  mem_addr = {t_r, x_r, ym, z_r};
      DIR_ZM:  mem_addr = {t_r, x_r, y_r, zm};
      default: mem_addr = {t_r, x_r, y_r, z_r};
    endcase
    if (state_r == ST_IDLE) begin
      mem_addr = wr_addr;
    end
  end

  assign mem_we = accept && (in_mode == MODE_WRITE);

  lsae_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_lattice (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({in_value_im, in_value_re}),
    .rdata (mem_rdata)
  );

  assign rd_re = mem_rdata[VAL_W-1:0];
  assign rd_im = mem_rdata[WORD_W-1:VAL_W];

  always_comb begin
    u_valid = 1'b0;
    u_v_re  = ctr_re_r;
    u_v_im  = ctr_im_r;
    u_a_re  = '0;
    u_a_im  = '0;
    u_b_re  = sum_re_r;
    u_b_im  = sum_im_r;
    priority if (state_r == ST_DOP1) begin
      u_valid = 1'b1;
      u_v_re  = p_re_r;
      u_v_im  = p_im_r;
      u_a_re  = {p_re_r[VAL_W-1], p_re_r} - {ctr_re_r[VAL_W-1], ctr_re_r};
      u_a_im  = {p_im_r[VAL_W-1], p_im_r} - {ctr_im_r[VAL_W-1], ctr_im_r};
    end else if (state_r == ST_DOP2) begin
      u_valid = 1'b1;
      u_b_re  = '0;
      u_b_im  = '0;
    end else if (state_r == ST_DCAP && tot_r && !tcap_r) begin
      u_valid = 1'b1;
      u_a_re  = {ctr_re_r[VAL_W-1], ctr_re_r};
      u_a_im  = {ctr_im_r[VAL_W-1], ctr_im_r};
    end else begin
      u_valid = 1'b0;
    end
  end

  lsae_term u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .lambda    (lambda_r),
    .kappa     (kappa_r),
    .in_valid  (u_valid),
    .in_v_re   (u_v_re),
    .in_v_im   (u_v_im),
    .in_a_re   (u_a_re),
    .in_a_im   (u_a_im),
    .in_b_re   (u_b_re),
    .in_b_im   (u_b_im),
    .out_valid (term_valid),
    .out_term  (term),
    .busy      (term_busy)
  );

  assign acc_sum   = {acc_r[ACT_W-1], acc_r} + {{(ACT_W+1-TERM_W){term[TERM_W-1]}}, term};
  assign delta     = {t1_r[TERM_W-1], t1_r} - {term[TERM_W-1], term};
  assign last_site = (t_r == TW'(EXTENT_T - 1)) && (x_r == XW'(EXTENT_X - 1))
                  && (y_r == YW'(EXTENT_Y - 1)) && (z_r == ZW'(EXTENT_Z - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rvalid_r  <= 1'b0;
      out_valid <= 1'b0;
      lambda_r  <= '0;
      kappa_r   <= '0;
      tot_r     <= 1'b0;
      tcap_r    <= 1'b0;
      first_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      out_valid <= 1'b0;
      rvalid_r  <= (state_r == ST_DRD) || (state_r == ST_TRD);
      rtag_r    <= cnt_r;

      if (cfg_valid) begin
        if (cfg_index == REG_QUARTIC) begin
          lambda_r <= cfg_data;
        end else if (cfg_index == REG_HOPPING) begin
          kappa_r <= cfg_data;
        end
      end

      // Read data of the previous cycle: either the centre word or a neighbour.
      if (rvalid_r) begin
        if (tot_r ? (rtag_r == '0) : (rtag_r == LAST_DELTA_RD)) begin
          ctr_re_r <= rd_re;
          ctr_im_r <= rd_im;
        end else begin
          sum_re_r <= sum_re_r + SUM_W'(rd_re);
          sum_im_r <= sum_im_r + SUM_W'(rd_im);
        end
      end

      if (term_valid) begin
        if (tot_r) begin
          if (acc_sum[ACT_W] != acc_sum[ACT_W-1]) begin
            acc_r <= acc_sum[ACT_W] ? {1'b1, {(ACT_W-1){1'b0}}} : {1'b0, {(ACT_W-1){1'b1}}};
          end else begin
            acc_r <= acc_sum[ACT_W-1:0];
          end
        end else if (!first_r) begin
          t1_r    <= term;
          first_r <= 1'b1;
        end else begin
          out_valid        <= 1'b1;
          out_action_value <= ACT_W'(delta);
          out_result_kind  <= KIND_DELTA;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_mode == MODE_DELTA || in_mode == MODE_TOTAL)) begin
            tot_r    <= (in_mode == MODE_TOTAL);
            first_r  <= 1'b0;
            cnt_r    <= '0;
            sum_re_r <= '0;
            sum_im_r <= '0;
            acc_r    <= '0;
            p_re_r   <= in_value_re;
            p_im_r   <= in_value_im;
            if (in_mode == MODE_DELTA) begin
              {t_r, x_r, y_r, z_r} <= wr_addr;
              state_r <= ST_DRD;
            end else begin
              {t_r, x_r, y_r, z_r} <= '0;
              state_r <= ST_TRD;
            end
          end
        end
        ST_DRD: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_DELTA_RD) begin
            state_r <= ST_DCAP;
            tcap_r  <= 1'b1;
          end
        end
        ST_TRD: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == LAST_TOTAL_RD) begin
            state_r <= ST_DCAP;
            tcap_r  <= 1'b1;
          end
        end
        ST_DCAP: begin
          // With tcap_r set it absorbs the last read; in total mode, with tcap_r clear, it issues the site.
          if (tcap_r) begin
            tcap_r <= 1'b0;
            if (!tot_r) begin
              state_r <= ST_DOP1;
            end
          end else begin
            sum_re_r <= '0;
            sum_im_r <= '0;
            cnt_r    <= '0;
            if (last_site) begin
              state_r <= ST_TWAIT;
            end else begin
              state_r <= ST_TRD;
              z_r <= zp;
              if (z_r == ZW'(EXTENT_Z - 1)) begin
                y_r <= yp;
                if (y_r == YW'(EXTENT_Y - 1)) begin
                  x_r <= xp;
                  if (x_r == XW'(EXTENT_X - 1)) begin
                    t_r <= tp;
                  end
                end
              end
            end
          end
        end
        ST_DOP1: state_r <= ST_DOP2;
        ST_DOP2: state_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (term_valid && first_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_TWAIT: begin
          if (!term_busy) begin
            out_valid        <= 1'b1;
            out_action_value <= acc_r;
            out_result_kind  <= KIND_TOTAL;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `LSAE_ASSERT_NXT(a_pulse, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `LSAE_ASSERT_NXT(a_query_busy, clk, rst_n, accept && (in_mode == MODE_DELTA), busy, "delta query did not start")
  `LSAE_ASSERT_IMP(a_term_busy, clk, rst_n, term_valid, busy, "arithmetic result while idle")
  `LSAE_ASSERT_IMP(a_read_busy, clk, rst_n, rvalid_r, !mem_we, "memory write during a read sweep")

endmodule

### tb/lattice_scalar_action_engine_tb.sv
// Self-checking testbench for the lattice scalar action engine.
`timescale 1ns / 1ps
module lattice_scalar_action_engine_tb;
  import lsae_pkg::*;

  localparam int unsigned SITES = DEF_EXTENT_T * DEF_EXTENT_X * DEF_EXTENT_Y * DEF_EXTENT_Z;
  localparam int unsigned HOLD_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ACT_HI = 64'sd140737488355327;
  localparam longint ACT_LO = -64'sd140737488355328;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic signed [47:0] action;
    logic               kind;
  } action_t;

  // Keeps a copy of the lattice and couplings and predicts each action result.
  class action_ledger;
    logic [31:0]  sites [SITES];
    logic [15:0]  lambda_q;
    logic [15:0]  kappa_q;
    action_t      pending_q [$];
    int           mismatches;

    function new();
      foreach (sites[i]) sites[i] = '0;
      lambda_q = '0;
      kappa_q = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == REG_QUARTIC) lambda_q = data;
      else if (idx == REG_HOPPING) kappa_q = data;
    endfunction

    function int site_of(int t, int x, int y, int z);
      return (((t % DEF_EXTENT_T) * DEF_EXTENT_X + (x % DEF_EXTENT_X)) * DEF_EXTENT_Y
              + (y % DEF_EXTENT_Y)) * DEF_EXTENT_Z + (z % DEF_EXTENT_Z);
    endfunction

    function longint re_of(int s);
      return longint'($signed(sites[s][15:0]));
    endfunction

    function longint im_of(int s);
      return longint'($signed(sites[s][31:16]));
    endfunction

    // lambda*(|v|^2-1)^2 + |v|^2 with 16 fractional bits, floored.
    function longint local_energy(longint re, longint im);
      longint m;
      longint d;
      logic [127:0] q;
      logic [127:0] prod;
      m = re * re + im * im;
      d = m - (64'sd1 <<< 24);
      q = 128'((d < 0) ? -d : d);
      prod = (128'(lambda_q) * q * q) >> 48;
      return longint'(prod[63:0]) + (m >>> 8);
    endfunction

    function longint hopping_energy(longint h);
      longint v;
      v = 2 * longint'(kappa_q) * h;
      return v >>> 24;
    endfunction

    function longint clamp_action(longint v);
      if (v > ACT_HI) return ACT_HI;
      if (v < ACT_LO) return ACT_LO;
      return v;
    endfunction

    function void note_command(logic [1:0] mode, int t, int x, int y, int z,
                               logic [15:0] vre, logic [15:0] vim);
      int c;
      int f [4];
      int b [4];
      longint sr, si, pr, pi, orr, oi, acc, vr, vi, fr, fi;
      action_t e;
      c = site_of(t, x, y, z);
      if (mode == MODE_WRITE) begin
        sites[c] = {vim, vre};
      end else if (mode == MODE_DELTA) begin
        f[0] = site_of(t + 1, x, y, z);
        f[1] = site_of(t, x + 1, y, z);
        f[2] = site_of(t, x, y + 1, z);
        f[3] = site_of(t, x, y, z + 1);
        b[0] = site_of(t + DEF_EXTENT_T - 1, x, y, z);
        b[1] = site_of(t, x + DEF_EXTENT_X - 1, y, z);
        b[2] = site_of(t, x, y + DEF_EXTENT_Y - 1, z);
        b[3] = site_of(t, x, y, z + DEF_EXTENT_Z - 1);
        sr = 0;
        si = 0;
        for (int k = 0; k < 4; k++) begin
          sr += re_of(f[k]) + re_of(b[k]);
          si += im_of(f[k]) + im_of(b[k]);
        end
        pr = longint'($signed(vre));
        pi = longint'($signed(vim));
        orr = re_of(c);
        oi = im_of(c);
        e.action = 48'(clamp_action(local_energy(pr, pi) - local_energy(orr, oi)
                   - hopping_energy((pr - orr) * sr + (pi - oi) * si)));
        e.kind = KIND_DELTA;
        pending_q.push_back(e);
      end else if (mode == MODE_TOTAL) begin
        acc = 0;
        for (int a = 0; a < DEF_EXTENT_T; a++)
          for (int bx = 0; bx < DEF_EXTENT_X; bx++)
            for (int cy = 0; cy < DEF_EXTENT_Y; cy++)
              for (int dz = 0; dz < DEF_EXTENT_Z; dz++) begin
                c = site_of(a, bx, cy, dz);
                f[0] = site_of(a + 1, bx, cy, dz);
                f[1] = site_of(a, bx + 1, cy, dz);
                f[2] = site_of(a, bx, cy + 1, dz);
                f[3] = site_of(a, bx, cy, dz + 1);
                vr = re_of(c);
                vi = im_of(c);
                fr = re_of(f[0]) + re_of(f[1]) + re_of(f[2]) + re_of(f[3]);
                fi = im_of(f[0]) + im_of(f[1]) + im_of(f[2]) + im_of(f[3]);
                acc = clamp_action(acc + local_energy(vr, vi)
                                   - hopping_energy(vr * fr + vi * fi));
              end
        e.action = 48'(acc);
        e.kind = KIND_TOTAL;
        pending_q.push_back(e);
      end
    endfunction

    function void check_result(logic signed [47:0] action, logic kind);
      action_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: action %0d kind %0d", action, kind);
        return;
      end
      e = pending_q.pop_front();
      if (action !== e.action || kind !== e.kind) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected action %0d kind %0d, got action %0d kind %0d",
                   e.action, e.kind, action, kind);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_mode;
  logic [2:0]            in_coord_t, in_coord_x, in_coord_y, in_coord_z;
  logic signed [15:0]    in_value_re, in_value_im;
  logic                  out_valid;
  logic signed [47:0]    out_action_value;
  logic                  out_result_kind;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_data;

  action_ledger ledger = new();
  longint       cycles = 0;

  lattice_scalar_action_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_coord_t(in_coord_t), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_value_re(in_value_re), .in_value_im(in_value_im),
    .out_valid(out_valid), .out_action_value(out_action_value),
    .out_result_kind(out_result_kind),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.check_result(out_action_value, out_result_kind);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 16'($signed($urandom_range(12288)) - 6144);
    if (r < 6) return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic send_command(logic [1:0] mode, logic [2:0] t, logic [2:0] x,
                              logic [2:0] y, logic [2:0] z,
                              logic [15:0] vre, logic [15:0] vim);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_coord_t <= t;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_value_re <= vre;
    in_value_im <= vim;
    do @(posedge clk); while (busy);
    ledger.note_command(mode, t, x, y, z, vre, vim);
  endtask

  task automatic send_random(logic [1:0] mode);
    send_command(mode, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                 pick_value(), pick_value());
  endtask

  // Lets every expected result arrive, then covers trailing no-result work.
  task automatic drain();
    start <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int r;
    logic [15:0] lam_set [4];
    logic [15:0] kap_set [4];
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_WRITE;
    in_coord_t <= '0;
    in_coord_x <= '0;
    in_coord_y <= '0;
    in_coord_z <= '0;
    in_value_re <= '0;
    in_value_im <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_QUARTIC;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An index past the register list must be ignored.
    write_register(CFG_IDX_W'(2 + $urandom_range(13)), 16'($urandom));

    // Every site is written before anything reads the lattice.
    for (int s = 0; s < SITES; s++)
      send_command(MODE_WRITE, 3'(s >> 9), 3'(s >> 6), 3'(s >> 3), 3'(s),
                   pick_value(), pick_value());

    lam_set[0] = 16'h0000; kap_set[0] = 16'h0000;
    lam_set[1] = 16'hffff; kap_set[1] = 16'hffff;
    lam_set[2] = 16'($urandom); kap_set[2] = 16'($urandom);
    lam_set[3] = 16'($urandom_range(4096)); kap_set[3] = 16'($urandom_range(8192));

    for (int p = 0; p < 4; p++) begin
      drain();
      write_register(REG_QUARTIC, lam_set[p]);
      write_register(REG_HOPPING, kap_set[p]);

      if (p == 1) begin
        // Corner sites, field extremes, the unused mode and a total query.
        send_command(MODE_DELTA, 3'd0, 3'd0, 3'd0, 3'd0, 16'h7fff, 16'h7fff);
        send_command(MODE_DELTA, 3'd7, 3'd7, 3'd7, 3'd7, 16'h8000, 16'h8000);
        send_command(MODE_DELTA, 3'd0, 3'd7, 3'd0, 3'd7, 16'h1000, 16'h0000);
        send_command(MODE_DELTA, 3'd7, 3'd0, 3'd7, 3'd0, 16'h0000, 16'h0000);
        send_command(MODE_WRITE, 3'd0, 3'd0, 3'd0, 3'd0, 16'h8000, 16'h7fff);
        send_command(MODE_WRITE, 3'd7, 3'd7, 3'd7, 3'd7, 16'h7fff, 16'h8000);
        send_command(MODE_DELTA, 3'd0, 3'd0, 3'd0, 3'd1, 16'h8000, 16'h7fff);
        send_command(MODE_DELTA, 3'd7, 3'd7, 3'd7, 3'd6, 16'hffff, 16'h0001);
        send_command(MODE_NONE, 3'd7, 3'd7, 3'd7, 3'd7, 16'hffff, 16'hffff);
        send_command(MODE_DELTA, 3'd0, 3'd0, 3'd0, 3'd0, 16'h7fff, 16'h8000);
        send_command(MODE_TOTAL, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0000);
      end

      for (int i = 0; i < 375; i++) begin
        if (i == 180) begin
          send_random(MODE_TOTAL);
          // Hold off until the block has delivered everything.
          if (p == 2) drain();
        end
        r = $urandom_range(99);
        if (r < 62) send_random(MODE_DELTA);
        else if (r < 97) send_random(MODE_WRITE);
        else send_random(MODE_NONE);
      end
      send_random(MODE_TOTAL);
    end

    drain();
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
